>>> rtl/core/timed_release_priority_queue_core_macros.svh
// Assertion macros for the timed-release priority queue core
`ifndef TIMED_RELEASE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define TIMED_RELEASE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define TRPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("trpq check failed");
`define TRPQ_NEVER(lbl, expr) \
  `TRPQ_ASSERT(lbl, !(expr))
`endif

>>> rtl/core/trpq_pkg.sv
// Types and constants for the timed-release priority queue
`default_nettype none
package trpq_pkg;
  localparam int QueueDepth = 64;
  localparam int TagBits    = 16;
  localparam int TimeBits   = 32;
  localparam int IdxBits    = $clog2(QueueDepth);
  localparam int OccBits    = $clog2(QueueDepth + 1);

  typedef enum logic {
    MODE_ENQUEUE = 1'b0,
    MODE_TICK    = 1'b1
  } mode_t;

  typedef struct packed {
    logic [TagBits-1:0]  tag;
    logic [TimeBits-1:0] due;
  } slot_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] packet_tag;
    logic [31:0] due_time;
    logic [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] released_tag;
    logic [31:0] released_time;
    logic        is_last;
    logic [31:0] released_total;
    logic [15:0] dropped_total;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_REL_RD,
    ST_REL_CHK,
    ST_REL_LAST,
    ST_CMP_RD,
    ST_CMP_WR
  } state_t;
endpackage
`default_nettype wire

>>> rtl/core/timed_release_priority_queue_core.sv
// Timed-release priority queue core: sorted single-memory store with sequencer
// Entries sit in one memory kept sorted by due time, then arrival; the memory has one
// read and one write port with a registered read. An enqueue into an empty queue, or to a
// full queue (dropped and counted), does not stall the input. Otherwise it walks down
// from the tail, reading and then comparing each entry and moving each later entry up
// one place, and stalls the input until it writes the new entry. A tick on an empty
// queue does not stall the input, and one that finds nothing due stalls only while it
// reads the head entry. A tick that releases packets reads each entry in turn, emits one
// result per entry released once the next entry (or the end) shows whether it is the
// last, then moves the remaining entries down, stalling the input throughout and also
// while a result waits on out_stall. No clearing pass is needed.
`default_nettype none
module timed_release_priority_queue_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire trpq_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output trpq_pkg::out_item_t       out_data
);
  import trpq_pkg::*;
`include "timed_release_priority_queue_core_macros.svh"

  slot_t mem [QueueDepth];
  slot_t rd_data;
  logic [IdxBits-1:0] rd_addr, wr_addr;
  logic wr_en;
  slot_t wr_data;

  state_t state, state_next;
  logic [OccBits-1:0] occupancy, occupancy_next;
  logic [OccBits-1:0] ptr, ptr_next;
  logic [OccBits-1:0] cnt, cnt_next;
  logic [31:0] release_counter;
  logic [15:0] drop_counter;
  slot_t item, item_next;
  slot_t cand, cand_next;
  logic [TimeBits-1:0] now, now_next;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic take;
  logic out_free;
  logic due_ok;
  logic later;
  logic is_tick;
  logic full;
  logic emit;
  logic emit_last;
  logic [OccBits-1:0] ptr_inc;
  assign take      = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign due_ok    = rd_data.due <= now;
  assign later     = rd_data.due > item.due;
  assign is_tick   = (in_data.mode == MODE_TICK);
  assign full      = (occupancy == OccBits'(QueueDepth));
  assign ptr_inc   = ptr + 1'b1;
  assign emit      = out_free && (((state == ST_REL_CHK) && (cnt != '0))
                                  || (state == ST_REL_LAST));
  assign emit_last = (state == ST_REL_LAST) || !due_ok;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:
        if (take) begin
          if (is_tick) begin
            if (occupancy != '0) state_next = ST_REL_RD;
          end else if (!full && occupancy != '0) begin
            state_next = ST_INS_RD;
          end
        end
      ST_INS_RD: state_next = ST_INS_CMP;
      ST_INS_CMP:
        if (!later) state_next = ST_IDLE;
        else if (ptr == '0) state_next = ST_INS_PUT;
        else state_next = ST_INS_RD;
      ST_INS_PUT: state_next = ST_IDLE;
      ST_REL_RD: state_next = ST_REL_CHK;
      ST_REL_CHK:
        if (cnt == '0) begin
          if (!due_ok) state_next = ST_IDLE;
          else state_next = (ptr_inc == occupancy) ? ST_REL_LAST : ST_REL_RD;
        end else if (out_free) begin
          if (!due_ok) state_next = ST_CMP_WR;
          else state_next = (ptr_inc == occupancy) ? ST_REL_LAST : ST_REL_RD;
        end
      ST_REL_LAST:
        if (out_free) state_next = ST_IDLE;
      ST_CMP_RD: state_next = ST_CMP_WR;
      ST_CMP_WR:
        if (ptr_inc == occupancy) state_next = ST_IDLE;
        else state_next = ST_CMP_RD;
      default: state_next = ST_IDLE;
    endcase
  end

  // enqueue: ptr = entry compared, hole above it
  // tick: ptr = entry read, cnt = entries taken, cand = release held back for is_last
  always_comb begin
    occupancy_next = occupancy;
    ptr_next       = ptr;
    cnt_next       = cnt;
    item_next      = item;
    cand_next      = cand;
    now_next       = now;
    rd_addr        = ptr[IdxBits-1:0];
    wr_en          = 1'b0;
    wr_addr        = ptr_inc[IdxBits-1:0];
    wr_data        = item;
    unique case (state)
      ST_IDLE:
        if (take) begin
          item_next = '{tag: TagBits'(in_data.packet_tag), due: TimeBits'(in_data.due_time)};
          now_next  = TimeBits'(in_data.current_time);
          cnt_next  = '0;
          if (is_tick) begin
            ptr_next = '0;
          end else if (!full) begin
            if (occupancy == '0) begin
              wr_en          = 1'b1;
              wr_addr        = '0;
              wr_data        = item_next;
              occupancy_next = OccBits'(1);
            end else begin
              ptr_next = occupancy - 1'b1;
            end
          end
        end
      ST_INS_CMP:
        if (later) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          if (ptr != '0) ptr_next = ptr - 1'b1;
        end else begin
          wr_en          = 1'b1;
          occupancy_next = occupancy + 1'b1;
        end
      ST_INS_PUT: begin
        wr_en          = 1'b1;
        wr_addr        = '0;
        occupancy_next = occupancy + 1'b1;
      end
      ST_REL_CHK:
        if ((cnt == '0 || out_free) && due_ok) begin
          cand_next = rd_data;
          cnt_next  = cnt + 1'b1;
          ptr_next  = ptr_inc;
        end
      ST_REL_LAST:
        if (out_free) occupancy_next = occupancy - cnt;
      ST_CMP_WR: begin
        wr_en    = 1'b1;
        wr_addr  = IdxBits'(ptr - cnt);
        wr_data  = rd_data;
        ptr_next = ptr_inc;
        if (ptr_inc == occupancy) occupancy_next = occupancy - cnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      occupancy       <= '0;
      ptr             <= '0;
      cnt             <= '0;
      item            <= '0;
      cand            <= '0;
      now             <= '0;
      release_counter <= '0;
      drop_counter    <= '0;
      out_valid       <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      ptr       <= ptr_next;
      cnt       <= cnt_next;
      item      <= item_next;
      cand      <= cand_next;
      now       <= now_next;
      if (take && !is_tick && full && drop_counter != 16'hFFFF)
        drop_counter <= drop_counter + 1'b1;
      if (emit) begin
        release_counter <= release_counter + 1'b1;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.released_tag   <= 16'(cand.tag);
      out_data.released_time  <= 32'(cand.due);
      out_data.is_last        <= emit_last;
      out_data.released_total <= release_counter + 1'b1;
      out_data.dropped_total  <= drop_counter;
    end
  end

  `TRPQ_NEVER(occ_bound, occupancy > OccBits'(QueueDepth))
  `TRPQ_NEVER(stall_on_busy, (state != ST_IDLE) && !in_stall)
  `TRPQ_ASSERT(emit_needs_room, emit |-> out_free)
  `TRPQ_ASSERT(out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
endmodule
`default_nettype wire

>>> tb/sv/timed_release_priority_queue_core_test.sv
// Testbench for the timed-release priority queue core: random and directed enqueue/tick traffic
`timescale 1ns / 100ps
`default_nettype none
module timed_release_priority_queue_core_test;
  import trpq_pkg::*;

  localparam int CycleLimit = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  timed_release_priority_queue_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  slot_t     sorted_slots[$];
  logic [31:0] release_count = '0;
  logic [15:0] drop_count = '0;
  out_item_t releases_due[$];
  in_item_t  pending_items[$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_off = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  took_in = 1'b0;

  function automatic void enlist(input in_item_t t);
    pending_items.insert(pending_items.size(), t);
  endfunction

  function automatic void predict(input in_item_t t);
    int pos;
    int n;
    out_item_t r;
    if (t.mode == MODE_ENQUEUE) begin
      if (sorted_slots.size() >= QueueDepth) begin
        if (drop_count != 16'hFFFF) drop_count++;
      end else begin
        pos = 0;
        while (pos < sorted_slots.size() && sorted_slots[pos].due <= t.due_time) pos++;
        sorted_slots.insert(pos, '{tag: t.packet_tag, due: t.due_time});
      end
    end else begin
      n = 0;
      while (n < sorted_slots.size() && sorted_slots[n].due <= t.current_time) n++;
      for (int k = 0; k < n; k++) begin
        release_count++;
        r.released_tag   = sorted_slots[0].tag;
        r.released_time  = sorted_slots[0].due;
        r.is_last        = (k == n - 1);
        r.released_total = release_count;
        r.dropped_total  = drop_count;
        releases_due.insert(releases_due.size(), r);
        void'(sorted_slots.pop_front());
      end
    end
  endfunction

  function automatic in_item_t make_item(input logic m, input logic [15:0] tg,
                                         input logic [31:0] dt, input logic [31:0] now);
    in_item_t t;
    t.mode = m;
    t.packet_tag = tg;
    t.due_time = dt;
    t.current_time = now;
    return t;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || took_in) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_off) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) in_gap <= int'($urandom_range(1, 7));
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= int'($urandom_range(1, 7)) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    took_in <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) predict(in_data);
      if (out_valid && !out_stall) begin
        if (releases_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected release: %p", out_data);
        end else begin
          want = releases_due.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("release mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
    end
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_random(input int count);
    logic [31:0] base;
    int pick;
    base = $urandom_range(0, 1000);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)
        enlist(make_item(MODE_ENQUEUE, 16'($urandom),
          (pick == 0) ? $urandom : base + $urandom_range(0, 60), $urandom));
      else begin
        base = base + $urandom_range(0, 30);
        enlist(make_item(MODE_TICK, 16'($urandom), $urandom,
          (pick == 9) ? $urandom : base));
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || releases_due.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: edge values, equal times, tick with nothing due, overflow
    enlist(make_item(MODE_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF));
    enlist(make_item(MODE_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0));
    enlist(make_item(MODE_ENQUEUE, 16'h0000, 32'h0, 32'hFFFF_FFFF));
    enlist(make_item(MODE_ENQUEUE, 16'h1111, 32'd5, 32'h0));
    enlist(make_item(MODE_ENQUEUE, 16'h2222, 32'd5, 32'h0));
    enlist(make_item(MODE_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'd4));
    enlist(make_item(MODE_TICK, 16'h0, 32'h0, 32'd5));
    enlist(make_item(MODE_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF));
    for (int i = 0; i < 66; i++)
      enlist(make_item(MODE_ENQUEUE, i[15:0], 32'(100 - i % 7), 32'h0));
    enlist(make_item(MODE_TICK, 16'h0, 32'h0, 32'd97));
    enlist(make_item(MODE_TICK, 16'h0, 32'h0, 32'hFFFF_FFFE));
    hold_off = 1'b0;
    drain();
    queue_random(170);
    wait (pending_items.size() == 0);
    hold_off = 1'b1;
    drain();
    hold_off = 1'b0;
    queue_random(150);
    wait (pending_items.size() == 0);
    quiet = 1'b1;
    queue_random(70);
    enlist(make_item(MODE_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF));
    drain();
    if (mismatches == 0 && releases_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
